FILE: hdl/mws_pkg.sv
package mws_pkg;

  localparam int SAMPLE_W       = 14;
  localparam int CFG_W          = 5;
  localparam int RING_DEPTH_DEF = 16;

  localparam logic [SAMPLE_W-1:0] JUMP_LIMIT   = SAMPLE_W'(300);
  localparam logic [SAMPLE_W-1:0] AGREE_MARGIN = SAMPLE_W'(100);

  localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(10);
  localparam logic [CFG_W-1:0] AGREE_RESET  = CFG_W'(5);

  // register index codes
  localparam logic REG_WINDOW_SIZE  = 1'b0;
  localparam logic REG_AGREE_NEEDED = 1'b1;

  typedef struct packed {
    logic write;
    logic start;
    logic reload;
    logic rotate;
    logic rank_en;
  } cell_ctl_t;

endpackage

FILE: hdl/mws_cell.sv
module mws_cell #(
  parameter int RING_DEPTH = mws_pkg::RING_DEPTH_DEF,
  parameter int INDEX      = 0,
  parameter int IW         = 4,
  parameter int CW         = 5
) (
  input  logic                         clk,
  input  mws_pkg::cell_ctl_t           ctl,
  input  logic [IW-1:0]                wr_pos,
  input  logic [mws_pkg::SAMPLE_W-1:0] sample,
  input  logic [CW-1:0]                count,
  input  logic [mws_pkg::SAMPLE_W-1:0] prev_value,
  input  logic [IW-1:0]                prev_tag,
  input  logic                         prev_valid,
  output logic [mws_pkg::SAMPLE_W-1:0] tok_value,
  output logic [IW-1:0]                tok_tag,
  output logic                         tok_valid
);
  import mws_pkg::*;

  logic [SAMPLE_W-1:0] value;
  logic [IW-1:0]       rank;
  logic                own_valid;
  logic                below;

  localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

  assign own_valid = (CW'(INDEX) < count) && (INDEX < RING_DEPTH);
  assign below     = (tok_value < value) || ((tok_value == value) && (tok_tag < MY_IDX));

  always_ff @(posedge clk) begin
    if (ctl.write && (wr_pos == MY_IDX)) begin
      value <= sample;
    end
    if (ctl.start) begin
      tok_value <= value;
      tok_tag   <= MY_IDX;
      tok_valid <= own_valid;
      rank      <= '0;
    end else if (ctl.reload) begin
      tok_value <= value;
      tok_tag   <= rank;
      tok_valid <= own_valid;
    end else if (ctl.rotate) begin
      tok_value <= prev_value;
      tok_tag   <= prev_tag;
      tok_valid <= prev_valid;
      if (ctl.rank_en && own_valid && tok_valid && below) begin
        rank <= rank + 1'b1;
      end
    end
  end

endmodule

FILE: hdl/mws_ctrl.sv
module mws_ctrl #(
  parameter int RING_DEPTH = mws_pkg::RING_DEPTH_DEF,
  parameter int IW         = 4,
  parameter int CW         = 5
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         sample_valid,
  output logic                         sample_stall,
  input  logic [mws_pkg::SAMPLE_W-1:0] soc_sample,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic [mws_pkg::SAMPLE_W-1:0] shown_soc,
  input  logic [CW-1:0]                win,
  input  logic [mws_pkg::CFG_W-1:0]    agree_needed,
  input  logic                         restart,
  output mws_pkg::cell_ctl_t           ctl,
  output logic [IW-1:0]                wr_pos,
  output logic [CW-1:0]                count,
  input  logic [mws_pkg::SAMPLE_W-1:0] tail_value,
  input  logic [IW-1:0]                tail_tag,
  input  logic                         tail_valid
);
  import mws_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOAD   = 3'd1;
  localparam logic [2:0] S_RANK   = 3'd2;
  localparam logic [2:0] S_RELOAD = 3'd3;
  localparam logic [2:0] S_SCAN   = 3'd4;
  localparam logic [2:0] S_MED    = 3'd5;
  localparam logic [2:0] S_DECIDE = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  localparam logic [IW-1:0] LAST_STEP = IW'(RING_DEPTH - 1);

  logic [2:0]          state;
  logic [IW-1:0]       step;
  logic [IW-1:0]       wp;
  logic                filled;
  logic [SAMPLE_W-1:0] shown;
  logic [SAMPLE_W-1:0] mid_lo;
  logic [SAMPLE_W-1:0] mid_hi;
  logic [SAMPLE_W-1:0] median;
  logic [CW-1:0]       agree_up;
  logic [CW-1:0]       agree_dn;

  logic                accept;
  logic [IW-1:0]       wp_eff;
  logic [CW-1:0]       wp_inc;
  logic                wrap;
  logic                even;
  logic [IW-1:0]       hi_rank;
  logic [IW-1:0]       lo_rank;
  logic [SAMPLE_W:0]   pair_sum;
  logic [SAMPLE_W:0]   up_bound;
  logic [SAMPLE_W:0]   dn_probe;
  logic                rising;
  logic [SAMPLE_W-1:0] diff;
  logic [CW-1:0]       agree;

  assign accept       = (state == S_IDLE) && sample_valid;
  assign sample_stall = (state != S_IDLE);
  assign wp_eff       = (CW'(wp) >= win) ? '0 : wp;
  assign wp_inc       = CW'(wp_eff) + 1'b1;
  assign wrap         = (wp_inc >= win);
  assign wr_pos       = wp_eff;
  assign count        = filled ? win : CW'(wp);

  assign even     = ~count[0];
  assign hi_rank  = IW'(count >> 1);
  assign lo_rank  = IW'((count >> 1) - 1'b1);
  assign pair_sum = {1'b0, mid_lo} + {1'b0, mid_hi};
  assign up_bound = {1'b0, shown} + {1'b0, AGREE_MARGIN};
  assign dn_probe = {1'b0, tail_value} + {1'b0, AGREE_MARGIN};
  assign rising   = (median > shown);
  assign diff     = rising ? (median - shown) : (shown - median);
  assign agree    = rising ? agree_up : agree_dn;

  always_comb begin
    ctl         = '0;
    ctl.write   = accept;
    ctl.start   = (state == S_LOAD);
    ctl.reload  = (state == S_RELOAD);
    ctl.rotate  = (state == S_RANK) || (state == S_SCAN);
    ctl.rank_en = (state == S_RANK);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      step         <= '0;
      wp           <= '0;
      filled       <= 1'b0;
      shown        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall && (state != S_DONE)) begin
        result_valid <= 1'b0;
      end
      if (restart) begin
        wp     <= '0;
        filled <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (sample_valid) begin
            if (wrap) begin
              wp     <= '0;
              filled <= 1'b1;
            end else begin
              wp <= IW'(wp_inc);
            end
            if ((shown == '0) && !wrap && (wp_inc == CW'(1))) begin
              shown <= soc_sample;
              state <= S_DONE;
            end else begin
              state <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          step     <= '0;
          agree_up <= '0;
          agree_dn <= '0;
          state    <= S_RANK;
        end
        S_RANK: begin
          step <= step + 1'b1;
          if (step == LAST_STEP) begin
            state <= S_RELOAD;
          end
        end
        S_RELOAD: begin
          step  <= '0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          step <= step + 1'b1;
          if (tail_valid) begin
            if (tail_tag == hi_rank) begin
              mid_hi <= tail_value;
            end
            if (even && (tail_tag == lo_rank)) begin
              mid_lo <= tail_value;
            end
            if ({1'b0, tail_value} > up_bound) begin
              agree_up <= agree_up + 1'b1;
            end
            if (dn_probe < {1'b0, shown}) begin
              agree_dn <= agree_dn + 1'b1;
            end
          end
          if (step == LAST_STEP) begin
            state <= S_MED;
          end
        end
        S_MED: begin
          median <= even ? pair_sum[SAMPLE_W:1] : mid_hi;
          state  <= S_DECIDE;
        end
        S_DECIDE: begin
          if (diff > JUMP_LIMIT) begin
            if (32'(agree) >= 32'(agree_needed)) begin
              shown <= median;
            end
          end else begin
            shown <= median;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!result_valid || !result_stall) begin
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && (!result_valid || !result_stall)) begin
      shown_soc <= shown;
    end
  end

endmodule

FILE: hdl/median_window_value_stabilizer_core.sv
// channel   | signals                                  | direction
// ----------+------------------------------------------+----------
// sample    | sample_valid, sample_stall, soc_sample   | in
// result    | result_valid, result_stall, shown_soc    | out
// config    | psel, penable, pwrite, paddr, pwdata ... | apb
//
// each sample takes two full rotations of the cell ring (rank pass, then
// median/agree scan at the ring tail); a first sample is shown directly
// synchronous active-high reset; ring entries hold no reset value
// the sample side stalls while a sample is in work or its result still waits
// a finished result sits in the output register until taken
module median_window_value_stabilizer_core #(
  parameter int RING_DEPTH = mws_pkg::RING_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         sample_valid,
  output logic                         sample_stall,
  input  logic [mws_pkg::SAMPLE_W-1:0] soc_sample,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic [mws_pkg::SAMPLE_W-1:0] shown_soc,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import mws_pkg::*;

  localparam int IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CW = $clog2(RING_DEPTH + 1);

  logic [CFG_W-1:0]    window_size;
  logic [CFG_W-1:0]    agree_needed;
  logic                cfg_write;
  logic                restart;
  logic [CW-1:0]       win;
  cell_ctl_t           ctl;
  logic [IW-1:0]       wr_pos;
  logic [CW-1:0]       count;

  logic [SAMPLE_W-1:0] tok_value [RING_DEPTH];
  logic [IW-1:0]       tok_tag   [RING_DEPTH];
  logic                tok_valid [RING_DEPTH];

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign restart   = cfg_write && (paddr[2] == REG_WINDOW_SIZE);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size  <= WINDOW_RESET;
      agree_needed <= AGREE_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_WINDOW_SIZE:  window_size  <= pwdata[CFG_W-1:0];
        REG_AGREE_NEEDED: agree_needed <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_WINDOW_SIZE:  prdata = {{(32-CFG_W){1'b0}}, window_size};
      REG_AGREE_NEEDED: prdata = {{(32-CFG_W){1'b0}}, agree_needed};
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    if (window_size == '0) begin
      win = CW'(1);
    end else if (32'(window_size) > RING_DEPTH) begin
      win = CW'(RING_DEPTH);
    end else begin
      win = CW'(window_size);
    end
  end

  mws_ctrl #(
    .RING_DEPTH (RING_DEPTH),
    .IW         (IW),
    .CW         (CW)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .soc_sample   (soc_sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .shown_soc    (shown_soc),
    .win          (win),
    .agree_needed (agree_needed),
    .restart      (restart),
    .ctl          (ctl),
    .wr_pos       (wr_pos),
    .count        (count),
    .tail_value   (tok_value[RING_DEPTH-1]),
    .tail_tag     (tok_tag[RING_DEPTH-1]),
    .tail_valid   (tok_valid[RING_DEPTH-1])
  );

  for (genvar i = 0; i < RING_DEPTH; i++) begin : g_cell
    localparam int PREV = (i + RING_DEPTH - 1) % RING_DEPTH;
    mws_cell #(
      .RING_DEPTH (RING_DEPTH),
      .INDEX      (i),
      .IW         (IW),
      .CW         (CW)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .wr_pos     (wr_pos),
      .sample     (soc_sample),
      .count      (count),
      .prev_value (tok_value[PREV]),
      .prev_tag   (tok_tag[PREV]),
      .prev_valid (tok_valid[PREV]),
      .tok_value  (tok_value[i]),
      .tok_tag    (tok_tag[i]),
      .tok_valid  (tok_valid[i])
    );
  end

endmodule
